### sv/sliding_window_maximum_top_macros.svh
// ----------------------------------------------------------------------------
// Sliding window maximum assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_TOP_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window maximum package
// Widths, types and the window size decode shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

	localparam int WINDOW_MAX = 16;
	localparam int SAMPLE_W   = 32;
	localparam int CFG_W      = 5;
	localparam int IDX_W      = $clog2(WINDOW_MAX);
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(3);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CFG_W-1:0] cfg_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Returns the index of the oldest sample covered by the window.
	function automatic idx_t last_index(input cfg_t ws);
		idx_t res;
		if (ws == '0) begin
			res = '0;
		end else if (CNT_W'(ws) > CNT_W'(WINDOW_MAX)) begin
			res = IDX_W'(WINDOW_MAX - 1);
		end else begin
			res = IDX_W'(ws - CFG_W'(1));
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### sv/swm_cell.sv
// ----------------------------------------------------------------------------
// Sliding window maximum cell
// Holds the maximum of the newest samples up to its own position in the row.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell (
	input  wire                   clk,
	input  wire                   en,
	input  wire swm_pkg::sample_t x,
	input  wire swm_pkg::sample_t prev,
	output swm_pkg::sample_t      max_q,
	output swm_pkg::sample_t      max_nx
);
	import swm_pkg::*;

	// The new sample joins the maximum that the neighbor held one beat earlier.
	assign max_nx = (prev > x) ? prev : x;

	always_ff @(posedge clk) begin
		if (en) begin
			max_q <= max_nx;
		end
	end

endmodule

`default_nettype wire

### sv/sliding_window_maximum_top.sv
// ----------------------------------------------------------------------------
// Sliding window maximum
// Running maximum over the newest window_size signed samples (0 acts as 1, above 16 as 16).
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  input     in_valid, in_stall, sample, first    sample beats in
//  output    out_valid, out_stall, window_max     maximum beats out
//  config    cfg_wr_en, cfg_wr_data               window_size write
//
// One input beat is taken every cycle while in_stall is low; a result is
// registered in window_max, or in skid_q while the output stalls. Each cell
// of the row does one signed compare per beat, and a single mux picks the
// cell for the window size. Reset clears the control state only. A two-entry
// output buffer absorbs one stalled result; the input stalls only while both entries are full.
`default_nettype none

module sliding_window_maximum_top (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire swm_pkg::sample_t sample,
	input  wire                   first,
	output logic                  out_valid,
	input  wire                   out_stall,
	output swm_pkg::sample_t      window_max,
	input  wire                   cfg_wr_en,
	input  wire swm_pkg::cfg_t    cfg_wr_data
);
	import swm_pkg::*;

	cfg_t    window_size_q;
	cnt_t    filled_q;
	cnt_t    filled_nx;
	idx_t    last_idx;
	logic    in_fire;
	logic    out_fire;
	logic    res_valid;
	sample_t res_value;
	logic    skid_valid_q;
	sample_t skid_q;
	sample_t cell_q  [WINDOW_MAX];
	sample_t cell_nx [WINDOW_MAX];

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !skid_valid_q;
	assign out_fire = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
		end else if (cfg_wr_en) begin
			window_size_q <= cfg_wr_data;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
			swm_cell u_cell (
				.clk    (clk),
				.en     (in_fire),
				.x      (sample),
				.prev   ((gi == 0) ? sample : cell_q[(gi == 0) ? 0 : gi - 1]),
				.max_q  (cell_q[gi]),
				.max_nx (cell_nx[gi])
			);
		end
	endgenerate

	always_comb begin
		if (first) begin
			filled_nx = CNT_W'(1);
		end else if (filled_q == CNT_W'(WINDOW_MAX)) begin
			filled_nx = filled_q;
		end else begin
			filled_nx = filled_q + CNT_W'(1);
		end
	end

	assign last_idx  = last_index(window_size_q);
	assign res_valid = in_fire && (filled_nx > CNT_W'(last_idx));
	assign res_value = cell_nx[last_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (in_fire) begin
			filled_q <= filled_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				window_max <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid && !out_fire) begin
				skid_q <= res_value;
			end else begin
				window_max <= res_value;
			end
		end
	end

endmodule

`default_nettype wire

### sv/swm_checker.sv
// ----------------------------------------------------------------------------
// Sliding window maximum port checker
// Watches the top level ports for output buffer and handshake behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_maximum_top_macros.svh"

module swm_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              in_stall,
	input wire              out_valid,
	input wire              out_stall,
	input swm_pkg::sample_t window_max
);
	import swm_pkg::*;

	`SWM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(window_max), "stalled output beat changed")
	`SWM_ASSERT_SAME(a_stall_full, clk, arst_n, in_stall, out_valid, "input stalled with an empty output")
	`SWM_ASSERT_NEXT(a_stall_drain, clk, arst_n, in_stall && !out_stall, !in_stall, "buffered beat not drained")
	`SWM_ASSERT_NEXT(a_stall_keep, clk, arst_n, in_stall && out_stall, in_stall, "buffered beat lost")

endmodule

bind sliding_window_maximum_top swm_checker u_swm_checker (.*);

`default_nettype wire
